/* design/pip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg - point-in-polygon test package
// Sizes, coordinate types, sequencer states and the datapath control struct.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int FIELD_BITS     = 32;   // width of the coordinate fields
  localparam int COORD_BITS     = 32;   // bits of a coordinate actually used
  localparam int MAX_VERTICES   = 64;
  localparam int MIN_POLY_VERTS = 3;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic        [ADDR_W-1:0]     addr_t;
  typedef logic        [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MUL_P,
    ST_MUL_Q,
    ST_CMP,
    ST_DONE
  } pip_state_t;

  // step select for the shared cross-product unit
  typedef struct packed {
    logic mul_p;
    logic mul_q;
  } pip_xctl_t;

endpackage : pip_pkg
`default_nettype wire

/* design/pip_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_if - request and result channels
// Valid/ready channels for vertex loads and queries, and for query results.
// ----------------------------------------------------------------------------
interface pip_req_if;
  import pip_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic                         start_new;
  logic signed [FIELD_BITS-1:0] coord_x;
  logic signed [FIELD_BITS-1:0] coord_y;

  modport source (output valid, req_type, start_new, coord_x, coord_y, input ready);
  modport sink   (input valid, req_type, start_new, coord_x, coord_y, output ready);
endinterface : pip_req_if

interface pip_res_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;
  logic overflowed;

  modport source (output valid, inside_res, degenerate, overflowed, input ready);
  modport sink   (input valid, inside_res, degenerate, overflowed, output ready);
endinterface : pip_res_if
`default_nettype wire

/* design/point_in_polygon_test.sv */
`timescale 1ns / 1ps
`default_nettype none
// Timing: a load gives no result; a query over n >= 3 vertices gives its result
//   once the edge walk ends, and one over n < 3 goes from idle straight to done.
// Flow: one load per cycle while idle; a query holds the input until its result
//   is registered, the single shared multiplier taking MUL_P, MUL_Q, CMP per edge.
// Reset (synchronous, rst high): vertex count and overflow flag cleared,
//   sequencer idle, no result pending. Vertex memory is not cleared.
// ----------------------------------------------------------------------------
// point_in_polygon_test - even-odd ray-casting point-in-polygon test
// Loads append vertices to a stored polygon. A query walks each edge (vertex
// i to vertex i-1, last vertex closing onto vertex 0) and flips the inside
// bit for every edge that straddles the query y and lies right of query x.
// ----------------------------------------------------------------------------
module point_in_polygon_test (
  input  wire logic clk,
  input  wire logic rst,
  pip_req_if.sink   req,
  pip_res_if.source res
);
  import pip_pkg::*;

  // Sequencer and control state
  pip_state_t state, state_next;
  cnt_t       count;        // vertices held
  logic       ovf;          // a vertex was dropped since the last clear
  cnt_t       idx;          // vertex i of the edge under test
  logic       res_valid;

  // Payload registers
  coord_t px, py;           // query point
  coord_t xj, yj;           // previous vertex of the walk
  logic   odd_cross;        // parity of the crossings so far
  logic   res_inside, res_degen, res_ovf;

  // Handshake and datapath wiring
  logic      req_ready;
  logic      load_xfer, query_xfer;
  logic      slot_free;
  logic      degen_now;
  cnt_t      base;
  logic      wen;
  addr_t     raddr;
  cnt_t      cnt_m1;
  coord_t    in_x, in_y;
  coord_t    rd_x, rd_y;
  pip_xctl_t xctl;
  logic      hit;

  assign in_x = req.coord_x[COORD_BITS-1:0];
  assign in_y = req.coord_y[COORD_BITS-1:0];

  assign load_xfer  = req.valid && req_ready && (req.req_type == REQ_LOAD);
  assign query_xfer = req.valid && req_ready && (req.req_type == REQ_QUERY);
  assign slot_free  = !res_valid || res.ready;
  assign degen_now  = count < cnt_t'(MIN_POLY_VERTS);
  assign cnt_m1     = count - cnt_t'(1);

  // A start flag restarts the polygon before this vertex is appended
  assign base = req.start_new ? '0 : count;
  assign wen  = load_xfer && (base < cnt_t'(MAX_VERTICES));

  pip_vertex_mem u_mem (
    .clk   (clk),
    .wen   (wen),
    .waddr (base[ADDR_W-1:0]),
    .wx    (in_x),
    .wy    (in_y),
    .raddr (raddr),
    .rd_x  (rd_x),
    .rd_y  (rd_y)
  );

  pip_cross_unit u_cross (
    .clk (clk),
    .ctl (xctl),
    .px  (px),
    .py  (py),
    .xi  (rd_x),
    .yi  (rd_y),
    .xj  (xj),
    .yj  (yj),
    .hit (hit)
  );

  // Next state and step controls. Read data comes from a registered read port,
  // so idle reads the last vertex so that priming can take it as vertex j.
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    xctl       = '0;
    raddr      = idx[ADDR_W-1:0];
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        raddr     = cnt_m1[ADDR_W-1:0];
        if (req.valid && (req.req_type == REQ_QUERY)) begin
          state_next = degen_now ? ST_DONE : ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_next = ST_MUL_P;
      end
      ST_MUL_P: begin
        xctl.mul_p = 1'b1;
        state_next = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        xctl.mul_q = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        // idx has already moved on, so equality marks the closing edge done
        state_next = (idx == count) ? ST_DONE : ST_MUL_P;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_xfer) begin
        if (base < cnt_t'(MAX_VERTICES)) begin
          count <= base + cnt_t'(1);
          ovf   <= req.start_new ? 1'b0 : ovf;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (state == ST_DONE && slot_free) begin
        res_valid <= 1'b1;
      end
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk) begin
    if (query_xfer) begin
      px        <= in_x;
      py        <= in_y;
      idx       <= '0;
      odd_cross <= 1'b0;
    end
    if (state == ST_PRIME) begin
      xj <= rd_x;
      yj <= rd_y;
    end
    if (state == ST_MUL_Q) begin
      // vertex i becomes vertex j of the next edge
      xj  <= rd_x;
      yj  <= rd_y;
      idx <= idx + cnt_t'(1);
    end
    if (state == ST_CMP && hit) begin
      odd_cross <= !odd_cross;
    end
    if (state == ST_DONE && slot_free) begin
      res_inside <= odd_cross;
      res_degen  <= degen_now;
      res_ovf    <= ovf;
    end
  end

  assign req.ready      = req_ready;
  assign res.valid      = res_valid;
  assign res.inside_res = res_inside;
  assign res.degenerate = res_degen;
  assign res.overflowed = res_ovf;

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(MAX_VERTICES))
    else $error("vertex count beyond store capacity");

  a_walk_needs_poly: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRIME || state == ST_MUL_P || state == ST_MUL_Q || state == ST_CMP)
      |-> count >= cnt_t'(MIN_POLY_VERTS))
    else $error("edge walk started on a degenerate polygon");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_P || state == ST_MUL_Q) |-> idx < count)
    else $error("edge index ran past the vertex count");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_xfer |=> state != ST_IDLE)
    else $error("query transfer did not leave idle");

  a_count_held: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> $stable(count))
    else $error("vertex count changed during a query");

endmodule : point_in_polygon_test
`default_nettype wire

/* design/pip_vertex_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_vertex_mem - polygon vertex store
// One write port, one registered read port; x and y held side by side.
// ----------------------------------------------------------------------------
module pip_vertex_mem (
  input  wire logic           clk,
  input  wire logic           wen,
  input  wire pip_pkg::addr_t waddr,
  input  wire pip_pkg::coord_t wx,
  input  wire pip_pkg::coord_t wy,
  input  wire pip_pkg::addr_t raddr,
  output pip_pkg::coord_t      rd_x,
  output pip_pkg::coord_t      rd_y
);
  import pip_pkg::*;

  coord_t mem_x [MAX_VERTICES];
  coord_t mem_y [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
  end

  always_ff @(posedge clk) begin
    rd_x <= mem_x[raddr];
    rd_y <= mem_y[raddr];
  end

endmodule : pip_vertex_mem
`default_nettype wire

/* design/pip_cross_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_cross_unit - shared cross-product compare
// One signed multiplier forms both cross terms of an edge on successive
// steps; a compare of the registered terms then decides if the edge is crossed.
// ----------------------------------------------------------------------------
module pip_cross_unit (
  input  wire logic               clk,
  input  wire pip_pkg::pip_xctl_t ctl,
  input  wire pip_pkg::coord_t    px,
  input  wire pip_pkg::coord_t    py,
  input  wire pip_pkg::coord_t    xi,
  input  wire pip_pkg::coord_t    yi,
  input  wire pip_pkg::coord_t    xj,
  input  wire pip_pkg::coord_t    yj,
  output logic                    hit
);
  import pip_pkg::*;

  diff_t op_a, op_b;
  prod_t prod;
  prod_t prod_p, prod_q;
  logic  straddle, dy_neg;

  function automatic diff_t sub(input coord_t a, input coord_t b);
    return diff_t'({a[COORD_BITS-1], a}) - diff_t'({b[COORD_BITS-1], b});
  endfunction

  // P = (px - xi) * (yj - yi), Q = (xj - xi) * (py - yi)
  always_comb begin
    if (ctl.mul_p) begin
      op_a = sub(px, xi);
      op_b = sub(yj, yi);
    end else begin
      op_a = sub(xj, xi);
      op_b = sub(py, yi);
    end
  end

  assign prod = prod_t'(op_a) * prod_t'(op_b);

  always_ff @(posedge clk) begin
    if (ctl.mul_p) begin
      prod_p   <= prod;
      straddle <= (yi > py) != (yj > py);
      dy_neg   <= yj < yi;
    end
    if (ctl.mul_q) begin
      prod_q <= prod;
    end
  end

  // rising edge: crossed when P < Q; falling edge: when P > Q
  assign hit = straddle && (dy_neg ? (prod_p > prod_q) : (prod_p < prod_q));

endmodule : pip_cross_unit
`default_nettype wire
